@@ rtl/ttx_pkg.sv @@
// ----------------------------------------------------------------------------
// ttx_pkg
// Shared types and constants of the tag table extractor.
// ----------------------------------------------------------------------------
package ttx_pkg;

   localparam int WIN_DEPTH = 6;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_BYTE = 1'b1;

   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_SHORT  = 3'd1;
   localparam logic [2:0] STAT_DUP    = 3'd2;
   localparam logic [2:0] STAT_OVFL   = 3'd3;
   localparam logic [2:0] STAT_TRUNC  = 3'd4;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;

   // per-cell match report
   typedef struct packed {
      logic       hit;    // first non-failing tag in slot order
      logic       pend;   // prefix matches, bytes still missing
      logic [2:0] need;   // bytes the tag occupies in the message
      logic       seen;   // slot already carried a nonzero length
   } cell_stat_type;

   typedef struct packed {
      logic [4:0] tag_index;
      logic [7:0] value_byte;
      logic       value_valid;
      logic       value_end;
      logic [9:0] store_offset;
      logic       message_done;
      logic [2:0] status;
   } result_type;

endpackage

@@ rtl/ttx_tag_cell.sv @@
// ----------------------------------------------------------------------------
// ttx_tag_cell
// One tag table slot: holds the tag and its seen flag, matches the tag
// against the lookahead window and passes the priority claim down the row.
// ----------------------------------------------------------------------------
module ttx_tag_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic [23:0]             load_tag,
   input  logic                    active,
   input  ttx_pkg::win_type        win,
   input  logic [2:0]              win_cnt,
   input  logic                    at_end,
   input  logic                    seen_clr,
   input  logic                    seen_set,
   input  logic                    claim_in,
   output logic                    claim_out,
   output ttx_pkg::cell_stat_type  stat
);
   import ttx_pkg::*;

   logic [23:0] tag_ff;
   logic        seen_ff;
   logic        seen_in;
   logic        is_hex;
   logic        is_two;
   logic [2:0]  need;
   logic        mism;
   logic        matched;
   logic        nonfail;
   logic [4:0]  hv;

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
      else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (load_en) tag_ff <= load_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) seen_ff <= 1'b0;
      else seen_ff <= seen_in;
   end

   always_comb begin
      seen_in = seen_ff;
      if (seen_clr) seen_in = 1'b0;
      else if (seen_set) seen_in = 1'b1;
   end

   always_comb begin
      is_hex = (tag_ff[23:16] == 8'hFF);
      is_two = (tag_ff[20:16] == 5'h1F);
      need = is_hex ? 3'd6 : (is_two ? 3'd2 : 3'd1);
      mism = 1'b0;
      hv = '0;
      if (is_hex) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            hv = hex_val(win[k]);
            if (3'(k) < win_cnt && (hv[4] || hv[3:0] != tag_ff[23-4*k -: 4])) mism = 1'b1;
         end
      end else begin
         for (int k = 0; k < 2; k++) begin
            if (3'(k) < win_cnt && 3'(k) < need && win[k] != tag_ff[23-8*k -: 8]) mism = 1'b1;
         end
      end
      matched = (win_cnt >= need);
      // a partial tag cannot match once the message has ended
      nonfail = active && !mism && (matched || !at_end);
      claim_out = claim_in | nonfail;
      stat.hit = !claim_in && nonfail;
      stat.pend = !matched;
      stat.need = need;
      stat.seen = seen_ff;
   end

endmodule

@@ rtl/tlv_tag_table_extractor.sv @@
// A loaded tag is taken while idle. A message byte is taken while idle too; the scan then
// makes its window steps (a skipped byte, a tag match or a length/value byte) and closes.
// No new byte is taken until the scan returns to idle, and the scan holds while a result
// waits untaken in the output register. Each result leaves through one output register.
// Reset is synchronous and clears all control state and seen flags; tag table
// entries hold no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// tlv_tag_table_extractor
// Scans a message byte by byte against a row of tag cells and emits the
// value bytes of matched tags with their slot and store offset.
// ----------------------------------------------------------------------------
module tlv_tag_table_extractor #(
   parameter int MAX_TAGS    = 32,
   parameter int STORE_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [4:0]  req_tag_slot,
   input  logic [23:0] req_tag_bytes,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_tag_index,
   output logic [7:0]  rsp_value_byte,
   output logic        rsp_value_valid,
   output logic        rsp_value_end,
   output logic [9:0]  rsp_store_offset,
   output logic        rsp_message_done,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);
   import ttx_pkg::*;

   localparam int SLOT_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int OFF_W  = $clog2(STORE_BYTES + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } eng_state_type;

   typedef enum logic [6:0] {
      PH_SCAN  = 7'b0000001,
      PH_BER1  = 7'b0000010,
      PH_BERN  = 7'b0000100,
      PH_ALEN  = 7'b0001000,
      PH_VALUE = 7'b0010000,
      PH_EDUP  = 7'b0100000,
      PH_EOVF  = 7'b1000000
   } phase_type;

   eng_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   win_type       win_ff, win_in;
   logic [2:0]    win_cnt_ff, win_cnt_in;
   logic [15:0]   accum_ff, accum_in;
   logic [15:0]   rem_ff, rem_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [1:0]    msg_ff, msg_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic          at_end_ff, at_end_in;
   logic [5:0]    tag_count_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   result_type    em;
   logic          em_valid;
   logic          go;
   logic          err;
   logic          clear;
   logic          ld;
   logic [15:0]   len_v;
   logic [15:0]   rem_dec;
   logic [15:0]   acc_v;
   logic [7:0]    b;
   logic [2:0]    pop_n;
   logic          load_hit;
   logic [SLOT_W-1:0] hit_idx;
   logic          hit_any;
   logic          hit_pend;
   logic [2:0]    hit_need;
   logic          hit_seen;
   logic [5:0]    slot_ext;
   logic [16:0]   off_ext;

   logic [MAX_TAGS-1:0] load_vec;
   logic [MAX_TAGS-1:0] seen_set_vec;
   logic [MAX_TAGS-1:0] hit_vec;
   logic [MAX_TAGS:0]   claim;
   cell_stat_type       stat [MAX_TAGS];

   assign claim[0] = 1'b0;

   for (genvar i = 0; i < MAX_TAGS; i++) begin : g_cell
      ttx_tag_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_en   (load_vec[i]),
         .load_tag  (req_tag_bytes),
         .active    (7'(i) < 7'(tag_count_ff)),
         .win       (win_ff),
         .win_cnt   (win_cnt_ff),
         .at_end    (at_end_ff),
         .seen_clr  (clear),
         .seen_set  (seen_set_vec[i]),
         .claim_in  (claim[i]),
         .claim_out (claim[i+1]),
         .stat      (stat[i])
      );
      assign hit_vec[i] = stat[i].hit;
   end

   always_comb begin
      hit_idx  = '0;
      hit_pend = 1'b0;
      hit_need = '0;
      hit_seen = 1'b0;
      for (int i = 0; i < MAX_TAGS; i++) begin
         if (stat[i].hit) begin
            hit_idx  = hit_idx | SLOT_W'(i);
            hit_pend = hit_pend | stat[i].pend;
            hit_need = hit_need | stat[i].need;
            hit_seen = hit_seen | stat[i].seen;
         end
      end
      hit_any = |hit_vec;
   end

   assign go        = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && go;
   assign err       = (phase_ff == PH_EDUP) || (phase_ff == PH_EOVF);
   assign slot_ext  = 6'(slot_ff);
   assign off_ext   = 17'(off_ff);
   assign rem_dec   = rem_ff - 16'd1;
   assign b         = win_ff[0];

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      win_in    = win_ff;
      win_cnt_in = win_cnt_ff;
      accum_in  = accum_ff;
      rem_in    = rem_ff;
      off_in    = off_ff;
      msg_in    = msg_ff;
      slot_in   = slot_ff;
      at_end_in = at_end_ff;
      em        = '0;
      em_valid  = 1'b0;
      clear     = 1'b0;
      ld        = 1'b0;
      len_v     = '0;
      acc_v     = '0;
      pop_n     = '0;
      load_hit  = 1'b0;
      seen_set_vec = '0;

      if (state_ff == ST_IDLE) begin
         if (req_valid && req_ready) begin
            if (req_command == CMD_LOAD) begin
               load_hit = (7'(req_tag_slot) < 7'(MAX_TAGS));
            end else if (req_last_byte && msg_ff == 2'd0) begin
               em_valid = 1'b1;
               em.message_done = 1'b1;
               em.status = STAT_SHORT;
               clear = 1'b1;
            end else begin
               if (msg_ff != 2'd2) msg_in = msg_ff + 2'd1;
               if (!err && win_cnt_ff < 3'(WIN_DEPTH)) begin
                  for (int k = 0; k < WIN_DEPTH; k++) begin
                     if (3'(k) == win_cnt_ff) win_in[k] = req_data_byte;
                  end
                  win_cnt_in = win_cnt_ff + 3'd1;
               end
               at_end_in = req_last_byte;
               state_in = ST_WORK;
            end
         end
      end else if (go) begin
         if (err || win_cnt_ff == 3'd0 || (phase_ff == PH_SCAN && hit_any && hit_pend)) begin
            if (err) win_cnt_in = '0;
            if (at_end_ff) begin
               em_valid = 1'b1;
               em.message_done = 1'b1;
               if (phase_ff == PH_EDUP) em.status = STAT_DUP;
               else if (phase_ff == PH_EOVF) em.status = STAT_OVFL;
               else if (phase_ff != PH_SCAN) em.status = STAT_TRUNC;
               else em.status = STAT_OK;
               clear = 1'b1;
            end
            state_in = ST_IDLE;
         end else if (phase_ff == PH_SCAN) begin
            if (!hit_any) begin
               pop_n = 3'd1;
            end else begin
               pop_n = hit_need;
               if (hit_seen) begin
                  phase_in = PH_EDUP;
               end else begin
                  slot_in  = hit_idx;
                  accum_in = '0;
                  if (hit_need == 3'd6) begin
                     phase_in = PH_ALEN;
                     rem_in   = 16'd3;
                  end else begin
                     phase_in = PH_BER1;
                  end
               end
            end
         end else begin
            pop_n = 3'd1;
            case (phase_ff)
               PH_BER1: begin
                  if (!b[7]) begin
                     ld = 1'b1;
                     len_v = 16'(b);
                  end else begin
                     accum_in = '0;
                     rem_in = 16'(b[6:0]);
                     if (b[6:0] == 7'd0) ld = 1'b1;
                     else phase_in = PH_BERN;
                  end
               end
               PH_BERN: begin
                  acc_v = {accum_ff[7:0], b};
                  accum_in = acc_v;
                  rem_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     ld = 1'b1;
                     len_v = acc_v;
                  end
               end
               PH_ALEN: begin
                  acc_v = (accum_ff << 3) + (accum_ff << 1) + 16'(b) - 16'h30;
                  accum_in = acc_v;
                  rem_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     ld = 1'b1;
                     len_v = acc_v;
                  end
               end
               PH_VALUE: begin
                  rem_in = rem_dec;
                  em_valid = 1'b1;
                  em.tag_index = slot_ext[4:0];
                  em.value_byte = b;
                  em.value_valid = 1'b1;
                  em.value_end = (rem_dec == 16'd0);
                  em.store_offset = off_ext[9:0];
                  off_in = off_ff + OFF_W'(1);
                  if (rem_dec == 16'd0) phase_in = PH_SCAN;
               end
               default: begin
               end
            endcase
         end

         // length complete: check the store, then open the value or report an empty one
         if (ld) begin
            if (off_ext + 17'(len_v) > 17'(STORE_BYTES)) begin
               phase_in = PH_EOVF;
            end else if (len_v == 16'd0) begin
               em_valid = 1'b1;
               em.tag_index = slot_ext[4:0];
               em.value_end = 1'b1;
               em.store_offset = off_ext[9:0];
               phase_in = PH_SCAN;
            end else begin
               seen_set_vec = MAX_TAGS'(1) << slot_ff;
               rem_in = len_v;
               phase_in = PH_VALUE;
            end
         end

         case (pop_n)
            3'd1: begin
               for (int k = 0; k < WIN_DEPTH - 1; k++) win_in[k] = win_ff[k+1];
               win_cnt_in = win_cnt_ff - 3'd1;
            end
            3'd2: begin
               for (int k = 0; k < WIN_DEPTH - 2; k++) win_in[k] = win_ff[k+2];
               win_cnt_in = win_cnt_ff - 3'd2;
            end
            3'd6: begin
               win_cnt_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (clear) begin
         phase_in   = PH_SCAN;
         win_cnt_in = '0;
         accum_in   = '0;
         rem_in     = '0;
         off_in     = '0;
         msg_in     = '0;
         slot_in    = '0;
         at_end_in  = 1'b0;
      end
   end

   always_comb begin
      load_vec = '0;
      for (int i = 0; i < MAX_TAGS; i++) begin
         load_vec[i] = load_hit && (7'(req_tag_slot) == 7'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SCAN;
         win_cnt_ff   <= '0;
         accum_ff     <= '0;
         rem_ff       <= '0;
         off_ff       <= '0;
         msg_ff       <= '0;
         slot_ff      <= '0;
         at_end_ff    <= 1'b0;
         tag_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         win_cnt_ff <= win_cnt_in;
         accum_ff   <= accum_in;
         rem_ff     <= rem_in;
         off_ff     <= off_in;
         msg_ff     <= msg_in;
         slot_ff    <= slot_in;
         at_end_ff  <= at_end_in;
         if (csr_wr_en) tag_count_ff <= csr_wr_data;
         if (go) rsp_valid_ff <= em_valid;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (go && em_valid) rsp_ff <= em;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tag_index    = rsp_ff.tag_index;
   assign rsp_value_byte   = rsp_ff.value_byte;
   assign rsp_value_valid  = rsp_ff.value_valid;
   assign rsp_value_end    = rsp_ff.value_end;
   assign rsp_store_offset = rsp_ff.store_offset;
   assign rsp_message_done = rsp_ff.message_done;
   assign rsp_status       = rsp_ff.status;

`ifndef SYNTH
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one tag cell claims the scan position");

   a_win_bound: assert property (@(posedge clock) disable iff (reset)
      win_cnt_ff <= 3'(WIN_DEPTH))
      else $error("lookahead window overfilled");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      32'(off_ff) <= 32'(STORE_BYTES))
      else $error("value offset beyond store");

   a_value_phase: assert property (@(posedge clock) disable iff (reset)
      (em_valid && em.value_valid) |-> (phase_ff == PH_VALUE && state_ff == ST_WORK))
      else $error("value byte emitted outside value phase");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives tag loads and message bytes into the tag table extractor, predicts
// every value and status result from a model of the scan, and checks each
// result in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import ttx_pkg::*;

   typedef struct {
      logic        command;
      logic [4:0]  slot;
      logic [23:0] tag;
      logic [7:0]  data;
      logic        last;
   } request_type;

   typedef enum {SCAN, BER_FIRST, BER_MORE, ASCII_LEN, VALUE, ERR_DUP, ERR_OVFL} phase_type;
   typedef enum {TRY_FAIL, TRY_MATCH, TRY_PEND} try_type;

   localparam int STORE_SIZE = 1024;
   localparam int SETTLE     = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_BYTE;
   logic [4:0]  req_tag_slot = '0;
   logic [23:0] req_tag_bytes = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_tag_index;
   logic [7:0]  rsp_value_byte;
   logic        rsp_value_valid;
   logic        rsp_value_end;
   logic [9:0]  rsp_store_offset;
   logic        rsp_message_done;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   tlv_tag_table_extractor i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type pending_requests[$];
   result_type  expected_results[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_asked = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   // scan model state
   logic [23:0] tag_mem[32];
   bit          seen_nz[32];
   logic [7:0]  window[6];
   int          win_n;
   phase_type   phase;
   bit [15:0]   len_acc;
   int          remaining;
   int          store_pos;
   int          msg_bytes;
   int          cur_slot;
   int          tag_cnt;
   int          step_n;

   logic [23:0] tag_mem_shadow[32];
   int          tags_live = 32;

   function automatic void push_result(int slot, int b, bit vld, bit fin, int off,
                                       bit done, logic [2:0] st);
      result_type r;
      if (step_n >= 8) return;
      r.tag_index    = slot[4:0];
      r.value_byte   = b[7:0];
      r.value_valid  = vld;
      r.value_end    = fin;
      r.store_offset = off[9:0];
      r.message_done = done;
      r.status       = st;
      expected_results.push_back(r);
      step_n++;
   endfunction

   function automatic void clear_scan();
      foreach (seen_nz[i]) seen_nz[i] = 0;
      win_n = 0; phase = SCAN; len_acc = 0; remaining = 0;
      store_pos = 0; msg_bytes = 0; cur_slot = 0;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return 16;
   endfunction

   function automatic try_type try_tag(logic [23:0] t, output int need);
      int lim;
      if (t[23:16] == 8'hFF) begin
         need = 6;
         lim = win_n < 6 ? win_n : 6;
         for (int k = 0; k < lim; k++) begin
            int d;
            d = hex_digit(window[k]);
            if (d > 15 || d != ((t >> (20 - 4 * k)) & 4'hF)) return TRY_FAIL;
         end
      end else begin
         need = (t[20:16] == 5'h1F) ? 2 : 1;
         lim = win_n < need ? win_n : need;
         for (int k = 0; k < lim; k++)
            if (window[k] != ((t >> (16 - 8 * k)) & 8'hFF)) return TRY_FAIL;
      end
      return win_n >= need ? TRY_MATCH : TRY_PEND;
   endfunction

   function automatic void drop_front(int cnt);
      if (cnt > win_n) cnt = win_n;
      for (int k = 0; k + cnt < win_n; k++) window[k] = window[k + cnt];
      win_n -= cnt;
   endfunction

   function automatic void length_known(bit [15:0] len);
      if (store_pos + len > STORE_SIZE) begin
         phase = ERR_OVFL;
         return;
      end
      if (len == 0) begin
         push_result(cur_slot, 0, 0, 1, store_pos, 0, STAT_OK);
         phase = SCAN;
         return;
      end
      seen_nz[cur_slot] = 1;
      remaining = len;
      phase = VALUE;
   endfunction

   function automatic void take_byte(logic [7:0] b);
      case (phase)
         BER_FIRST: begin
            if (b <= 127) length_known(b);
            else begin
               len_acc = 0;
               remaining = b & 8'h7F;
               if (remaining == 0) length_known(0);
               else phase = BER_MORE;
            end
         end
         BER_MORE: begin
            len_acc = {len_acc[7:0], b};
            remaining--;
            if (remaining == 0) length_known(len_acc);
         end
         ASCII_LEN: begin
            len_acc = len_acc * 16'd10 + ({8'h00, b} - 16'h30);
            remaining--;
            if (remaining == 0) length_known(len_acc);
         end
         VALUE: begin
            remaining--;
            push_result(cur_slot, b, 1, remaining == 0, store_pos, 0, STAT_OK);
            store_pos++;
            if (remaining == 0) phase = SCAN;
         end
         default: ;
      endcase
   endfunction

   function automatic void run_scan(bit at_end);
      int cnt;
      cnt = tag_cnt < 32 ? tag_cnt : 32;
      while (1) begin
         if (phase == ERR_DUP || phase == ERR_OVFL) begin
            win_n = 0;
            return;
         end
         if (win_n == 0) return;
         if (phase == SCAN) begin
            int need, hit;
            bit hold;
            try_type s;
            need = 0; hit = cnt; hold = 0;
            for (int i = 0; i < cnt; i++) begin
               s = try_tag(tag_mem[i], need);
               if (s == TRY_FAIL) continue;
               if (s == TRY_PEND) begin
                  if (at_end) continue;
                  hold = 1;
                  break;
               end
               hit = i;
               break;
            end
            if (hold) return;
            if (hit == cnt) begin
               drop_front(1);
               continue;
            end
            drop_front(need);
            if (seen_nz[hit]) begin
               phase = ERR_DUP;
               continue;
            end
            cur_slot = hit;
            len_acc = 0;
            if (need == 6) begin
               phase = ASCII_LEN;
               remaining = 3;
            end else phase = BER_FIRST;
         end else begin
            logic [7:0] b;
            b = window[0];
            drop_front(1);
            take_byte(b);
         end
      end
   endfunction

   function automatic void predict_request(request_type q);
      logic [2:0] st;
      step_n = 0;
      if (q.command == CMD_LOAD) begin
         tag_mem[q.slot] = q.tag;
         return;
      end
      if (q.last && msg_bytes == 0) begin
         push_result(0, 0, 0, 0, 0, 1, STAT_SHORT);
         clear_scan();
         return;
      end
      if (msg_bytes < 2) msg_bytes++;
      if (phase != ERR_DUP && phase != ERR_OVFL && win_n < 6) begin
         window[win_n] = q.data;
         win_n++;
      end
      run_scan(q.last);
      if (q.last) begin
         if (phase == ERR_DUP) st = STAT_DUP;
         else if (phase == ERR_OVFL) st = STAT_OVFL;
         else if (phase != SCAN) st = STAT_TRUNC;
         else st = STAT_OK;
         push_result(0, 0, 0, 0, 0, 1, st);
         clear_scan();
      end
   endfunction

   // driver: predict on acceptance, then offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_request('{req_command, req_tag_slot, req_tag_bytes, req_data_byte,
                              req_last_byte});
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               request_type q;
               q = pending_requests.pop_front();
               req_valid     <= 1'b1;
               req_command   <= q.command;
               req_tag_slot  <= q.slot;
               req_tag_bytes <= q.tag;
               req_data_byte <= q.data;
               req_last_byte <= q.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, asked for by the stimulus
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left  <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0 || hold_asked != hold_taken) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_type got, want;
         got = '{rsp_tag_index, rsp_value_byte, rsp_value_valid, rsp_value_end,
                 rsp_store_offset, rsp_message_done, rsp_status};
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   task automatic add_req(logic cmd, logic [4:0] slot, logic [23:0] tag, logic [7:0] data,
                          logic last);
      request_type q;
      q = '{cmd, slot, tag, data, last};
      pending_requests.push_back(q);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [23:0] random_tag(int slot);
      logic [7:0] f;
      case (slot % 3)
         0: return {8'hFF, 16'($urandom)};
         1: return {3'($urandom), 5'h1F, 8'($urandom), 8'h00};
         default: begin
            do f = 8'($urandom); while (f[4:0] == 5'h1F);
            return {f, 16'h0000};
         end
      endcase
   endfunction

   // append one tag, its length and vlen value bytes
   task automatic add_item(ref logic [7:0] msg[$], input int slot, input int len,
                           input int vlen);
      logic [23:0] t;
      int nb;
      t = tag_mem_shadow[slot];
      if (t[23:16] == 8'hFF) begin
         for (int k = 0; k < 6; k++) msg.push_back(hex_char(4'(t >> (20 - 4 * k))));
         msg.push_back(8'("0" + (len / 100) % 10));
         msg.push_back(8'("0" + (len / 10) % 10));
         msg.push_back(8'("0" + len % 10));
      end else begin
         msg.push_back(t[23:16]);
         if (t[20:16] == 5'h1F) msg.push_back(t[15:8]);
         if (len < 128 && $urandom_range(1)) msg.push_back(len[7:0]);
         else begin
            nb = $urandom_range(3, 1);
            if (len > 255 && nb < 2) nb = 2;
            msg.push_back(8'h80 | nb[7:0]);
            for (int k = nb - 1; k >= 0; k--) msg.push_back(8'(len >> (8 * k)));
         end
      end
      for (int k = 0; k < vlen; k++) msg.push_back(8'($urandom));
   endtask

   task automatic send_message(logic [7:0] msg[$]);
      foreach (msg[k]) add_req(CMD_BYTE, '0, '0, msg[k], k == msg.size() - 1);
   endtask

   // kinds: 0 clean, 1 duplicate, 2 overflow, 3 truncated, 4 noise, 5 too short
   task automatic build_message(int kind);
      logic [7:0] msg[$];
      int slot, len, n;
      if (kind == 5 || tags_live == 0) begin
         n = (kind == 5) ? 0 : $urandom_range(5);
         for (int k = 0; k <= n; k++) msg.push_back(8'($urandom));
         send_message(msg);
         return;
      end
      if (kind == 4) begin
         n = $urandom_range(12, 2);
         for (int k = 0; k < n; k++) msg.push_back(8'($urandom));
         send_message(msg);
         return;
      end
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
         slot = $urandom_range(tags_live - 1);
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
         if ($urandom_range(3) == 0) msg.push_back(8'($urandom));
         add_item(msg, slot, len, len);
         if (kind == 1 && i == n - 1) add_item(msg, slot, 2, 2);
      end
      if (kind == 2) begin
         slot = $urandom_range(tags_live - 1);
         add_item(msg, slot, (tag_mem_shadow[slot][23:16] == 8'hFF) ? 999 :
                  $urandom_range(65535, 1025), 2);
      end
      if (kind == 3) begin
         slot = $urandom_range(tags_live - 1);
         len = $urandom_range(8, 3);
         add_item(msg, slot, len, $urandom_range(len - 1));
         send_message(msg);
         return;
      end
      // trailing byte marks the end
      msg.push_back(8'($urandom));
      send_message(msg);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tag_count(logic [5:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tag_cnt = v;
      tags_live = v < 32 ? v : 32;
   endtask

   task automatic random_phase(logic [5:0] cnt, int idle_mode, int items);
      int goal;
      int pct[4] = '{0, 68, 0, 33};
      int rpct[4] = '{0, 0, 68, 33};
      wait_drained();
      write_tag_count(cnt);
      send_idle_pct  = pct[idle_mode];
      recv_stall_pct = rpct[idle_mode];
      goal = pending_requests.size() + items;
      while (pending_requests.size() < goal) begin
         int r;
         r = $urandom_range(99);
         if (r < 60) build_message(0);
         else if (r < 68) build_message(1);
         else if (r < 74) build_message(2);
         else if (r < 82) build_message(3);
         else if (r < 90) build_message(4);
         else if (r < 94) build_message(5);
         else begin
            int s;
            s = $urandom_range(31);
            tag_mem_shadow[s] = random_tag(s);
            add_req(CMD_LOAD, 5'(s), tag_mem_shadow[s], 8'($urandom),
                    1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      clear_scan();
      tag_cnt = 0;
      foreach (tag_mem[i]) tag_mem[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_tag_count(6'd32);
      for (int s = 0; s < 32; s++) begin
         tag_mem_shadow[s] = random_tag(s);
         add_req(CMD_LOAD, 5'(s), tag_mem_shadow[s], 8'($urandom), 1'($urandom_range(1)));
      end
      // directed: too short, clean, zero long form, duplicate, overflow, truncated, noise
      build_message(5);
      build_message(0);
      begin
         logic [7:0] msg[$];
         msg = '{8'h00};
         add_item(msg, 2, 0, 0);
         msg[msg.size() - 1] = 8'h80;
         add_item(msg, 0, 3, 3);
         add_req(CMD_LOAD, 5'd31, tag_mem_shadow[31], 8'hFF, 1'b1);
         msg.push_back(tag_mem_shadow[1][23:16]);
         send_message(msg);
      end
      build_message(1);
      build_message(2);
      build_message(3);
      build_message(4);
      wait_drained();
      // long receiver hold while the sender keeps offering
      recv_stall_pct = 0;
      hold_asked = hold_asked + 1;
      random_phase(6'd32, 0, 40);
      random_phase(6'd63, 1, 35);
      random_phase(6'd1, 2, 25);
      random_phase(6'd0, 3, 20);
      random_phase(6'd7, 0, 35);
      random_phase(6'd33, 2, 35);
      random_phase(6'($urandom_range(31, 2)), 3, 35);
      random_phase(6'd32, 1, 35);
      wait_drained();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ttx_pkg.sv
rtl/ttx_tag_cell.sv
rtl/tlv_tag_table_extractor.sv
bench/testbench.sv
